>>> src/vspc_pkg.sv
// ----------------------------------------------------------------------------
// vspc_pkg: shared constants for the version string parser and comparator
// Character codes, field and register codes, and the encoding of the order.
// ----------------------------------------------------------------------------
`default_nettype none

package vspc_pkg;

  // Default width of one parsed version component.
  localparam int COMPONENT_WIDTH_DEF = 16;

  // Width of the reported fields and of the configuration registers.
  localparam int NUM_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 2;

  // Characters the parser recognizes.
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // Field being parsed.
  localparam logic [1:0] FIELD_MAJOR = 2'd0;
  localparam logic [1:0] FIELD_MINOR = 2'd1;
  localparam logic [1:0] FIELD_PATCH = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CUR_MAJOR = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CUR_MINOR = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CUR_PATCH = 2'd2;

  // Sign of parsed minus current version.
  localparam logic signed [1:0] ORD_LT = -2'sd1;
  localparam logic signed [1:0] ORD_EQ = 2'sd0;
  localparam logic signed [1:0] ORD_GT = 2'sd1;

  // Control handed from the parser to the result stage.
  typedef struct packed {
    logic fire;  // a string ends in this cycle
    logic ok;    // the string that ends is well formed
  } res_ctl_t;

endpackage

`default_nettype wire

>>> src/vspc_parse.sv
// ----------------------------------------------------------------------------
// vspc_parse: per-character parse state
// Accumulates the three decimal fields and tracks format errors.
// ----------------------------------------------------------------------------
`default_nettype none

module vspc_parse #(
  parameter int COMPONENT_WIDTH = vspc_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [7:0]                 ch,
  input  wire logic                       last,
  output vspc_pkg::res_ctl_t              ctl,
  output logic      [COMPONENT_WIDTH-1:0] major_nxt,
  output logic      [COMPONENT_WIDTH-1:0] minor_nxt,
  output logic      [COMPONENT_WIDTH-1:0] patch_nxt
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int XW = COMPONENT_WIDTH + 4;

  logic [1:0]    fidx_r, fidx_nxt;
  logic [CW-1:0] major_r, minor_r, patch_r;
  logic          dseen_r, dseen_nxt;
  logic          zlead_r, zlead_nxt;
  logic          bad_r, bad_nxt;

  logic          is_digit, is_dot;
  logic [7:0]    diff;
  logic [3:0]    dval;
  logic [CW-1:0] acc_sel;
  logic [XW-1:0] acc_x, acc_mul;
  logic          ovf;

  // Character decode.
  assign is_digit = (ch >= vspc_pkg::CHAR_ZERO) && (ch <= vspc_pkg::CHAR_NINE);
  assign is_dot   = (ch == vspc_pkg::CHAR_DOT);
  assign diff     = ch - vspc_pkg::CHAR_ZERO;
  assign dval     = diff[3:0];

  // Current field's accumulator times ten plus the new digit.
  always_comb begin
    case (fidx_r)
      vspc_pkg::FIELD_MAJOR: acc_sel = major_r;
      vspc_pkg::FIELD_MINOR: acc_sel = minor_r;
      default:               acc_sel = patch_r;
    endcase
  end

  assign acc_x   = XW'(acc_sel);
  assign acc_mul = (acc_x << 3) + (acc_x << 1) + XW'(dval);
  assign ovf     = |acc_mul[XW-1:CW];

  // Next parse state for the character at hand.
  always_comb begin
    fidx_nxt  = fidx_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    patch_nxt = patch_r;
    dseen_nxt = dseen_r;
    zlead_nxt = zlead_r;
    bad_nxt   = bad_r;
    if (!bad_r) begin
      if (is_digit) begin
        if ((dseen_r && zlead_r) || ovf) begin
          bad_nxt = 1'b1;
        end else begin
          case (fidx_r)
            vspc_pkg::FIELD_MAJOR: major_nxt = acc_mul[CW-1:0];
            vspc_pkg::FIELD_MINOR: minor_nxt = acc_mul[CW-1:0];
            default:               patch_nxt = acc_mul[CW-1:0];
          endcase
          if (!dseen_r && (dval == 4'd0)) begin
            zlead_nxt = 1'b1;
          end
          dseen_nxt = 1'b1;
        end
      end else if (is_dot) begin
        if (!dseen_r || (fidx_r == vspc_pkg::FIELD_PATCH)) begin
          bad_nxt = 1'b1;
        end else begin
          fidx_nxt  = fidx_r + 2'd1;
          dseen_nxt = 1'b0;
          zlead_nxt = 1'b0;
        end
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  // Result control: a string is good if it reached patch with a digit there.
  assign ctl.fire = step && last;
  assign ctl.ok   = !bad_nxt && (fidx_nxt == vspc_pkg::FIELD_PATCH) && dseen_nxt;

  // State registers; the state clears once a string ends.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      fidx_r  <= vspc_pkg::FIELD_MAJOR;
      major_r <= '0;
      minor_r <= '0;
      patch_r <= '0;
      dseen_r <= 1'b0;
      zlead_r <= 1'b0;
      bad_r   <= 1'b0;
    end else if (step) begin
      fidx_r  <= fidx_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      patch_r <= patch_nxt;
      dseen_r <= dseen_nxt;
      zlead_r <= zlead_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/vspc_result.sv
// ----------------------------------------------------------------------------
// vspc_result: version compare and result register
// Orders the parsed version against the current one and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module vspc_result #(
  parameter int COMPONENT_WIDTH = vspc_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire vspc_pkg::res_ctl_t                   ctl,
  input  wire logic [COMPONENT_WIDTH-1:0]           major_in,
  input  wire logic [COMPONENT_WIDTH-1:0]           minor_in,
  input  wire logic [COMPONENT_WIDTH-1:0]           patch_in,
  input  wire logic [vspc_pkg::NUM_WIDTH-1:0]       cur_major,
  input  wire logic [vspc_pkg::NUM_WIDTH-1:0]       cur_minor,
  input  wire logic [vspc_pkg::NUM_WIDTH-1:0]       cur_patch,
  output logic                                      slot_free,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_valid_res,
  output logic      [vspc_pkg::NUM_WIDTH-1:0]       out_major_num,
  output logic      [vspc_pkg::NUM_WIDTH-1:0]       out_minor_num,
  output logic      [vspc_pkg::NUM_WIDTH-1:0]       out_patch_num,
  output logic signed [1:0]                         out_order,
  output logic                                      out_newer
);

  localparam int NW   = vspc_pkg::NUM_WIDTH;
  localparam int CMPW = (COMPONENT_WIDTH > vspc_pkg::NUM_WIDTH) ?
                        COMPONENT_WIDTH : vspc_pkg::NUM_WIDTH;

  logic [CMPW-1:0]   pmaj, pmin, ppat, cmaj, cmin, cpat;
  logic signed [1:0] ord;

  logic              out_valid_r;
  logic              valid_res_r, newer_r;
  logic [NW-1:0]     major_r, minor_r, patch_r;
  logic signed [1:0] order_r;

  // Compare at full width.
  assign pmaj = CMPW'(major_in);
  assign pmin = CMPW'(minor_in);
  assign ppat = CMPW'(patch_in);
  assign cmaj = CMPW'(cur_major);
  assign cmin = CMPW'(cur_minor);
  assign cpat = CMPW'(cur_patch);

  // Lexicographic order: major first, then minor, then patch.
  always_comb begin
    if (!ctl.ok) begin
      ord = vspc_pkg::ORD_EQ;
    end else if (pmaj > cmaj) begin
      ord = vspc_pkg::ORD_GT;
    end else if (pmaj < cmaj) begin
      ord = vspc_pkg::ORD_LT;
    end else if (pmin > cmin) begin
      ord = vspc_pkg::ORD_GT;
    end else if (pmin < cmin) begin
      ord = vspc_pkg::ORD_LT;
    end else if (ppat > cpat) begin
      ord = vspc_pkg::ORD_GT;
    end else if (ppat < cpat) begin
      ord = vspc_pkg::ORD_LT;
    end else begin
      ord = vspc_pkg::ORD_EQ;
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result word; numbers read as zero for a malformed string.
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      valid_res_r <= ctl.ok;
      major_r     <= ctl.ok ? pmaj[NW-1:0] : '0;
      minor_r     <= ctl.ok ? pmin[NW-1:0] : '0;
      patch_r     <= ctl.ok ? ppat[NW-1:0] : '0;
      order_r     <= ord;
      newer_r     <= (ord == vspc_pkg::ORD_GT);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = valid_res_r;
  assign out_major_num = major_r;
  assign out_minor_num = minor_r;
  assign out_patch_num = patch_r;
  assign out_order     = order_r;
  assign out_newer     = newer_r;

endmodule

`default_nettype wire

>>> src/version_string_parse_compare.sv
// A result word is registered: the last character of a string passes through the input
// register and the parse step into the result register. Throughput: one character per
// cycle while the result register is not full and untaken; it is the only stall point.
// Reset (synchronous, active low) clears the parse state, empties both
// registers and sets the current version to 0.0.0.
// ----------------------------------------------------------------------------
// version_string_parse_compare: version string parser and comparator
// Parses MAJOR.MINOR.PATCH one character per word and orders it against the
// configured current version.
// ----------------------------------------------------------------------------
`default_nettype none

module version_string_parse_compare #(
  parameter int COMPONENT_WIDTH = vspc_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [vspc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  wire logic [vspc_pkg::NUM_WIDTH-1:0]       cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [7:0]                           in_ch,
  input  wire logic                                 in_last,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_valid_res,
  output logic      [vspc_pkg::NUM_WIDTH-1:0]       out_major_num,
  output logic      [vspc_pkg::NUM_WIDTH-1:0]       out_minor_num,
  output logic      [vspc_pkg::NUM_WIDTH-1:0]       out_patch_num,
  output logic signed [1:0]                         out_order,
  output logic                                      out_newer
);

  localparam int CW = COMPONENT_WIDTH;

  logic [vspc_pkg::NUM_WIDTH-1:0] cur_major_r, cur_minor_r, cur_patch_r;
  logic                           in_v_r;
  logic [7:0]                     ch_r;
  logic                           last_r;
  logic                           adv;
  logic                           slot_free;
  vspc_pkg::res_ctl_t             ctl;
  logic [CW-1:0]                  major_nxt, minor_nxt, patch_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_major_r <= '0;
      cur_minor_r <= '0;
      cur_patch_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vspc_pkg::REG_CUR_MAJOR: cur_major_r <= cfg_wdata;
        vspc_pkg::REG_CUR_MINOR: cur_minor_r <= cfg_wdata;
        vspc_pkg::REG_CUR_PATCH: cur_patch_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A held character moves on unless it ends a string and the result is full and not taken.
  assign adv      = in_v_r && (!last_r || slot_free);
  assign in_ready = !in_v_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r   <= in_ch;
      last_r <= in_last;
    end
  end

  vspc_parse #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .ch       (ch_r),
    .last     (last_r),
    .ctl      (ctl),
    .major_nxt(major_nxt),
    .minor_nxt(minor_nxt),
    .patch_nxt(patch_nxt)
  );

  vspc_result #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_result (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .major_in     (major_nxt),
    .minor_in     (minor_nxt),
    .patch_in     (patch_nxt),
    .cur_major    (cur_major_r),
    .cur_minor    (cur_minor_r),
    .cur_patch    (cur_patch_r),
    .slot_free    (slot_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_valid_res(out_valid_res),
    .out_major_num(out_major_num),
    .out_minor_num(out_minor_num),
    .out_patch_num(out_patch_num),
    .out_order    (out_order),
    .out_newer    (out_newer)
  );

  // A malformed string reports no order and is never newer.
  a_bad_res_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_order == vspc_pkg::ORD_EQ && !out_newer))
    else $error("malformed string reported an order");

  // Newer means well formed and strictly greater.
  a_newer_gt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_newer) |-> (out_valid_res && out_order == vspc_pkg::ORD_GT))
    else $error("newer flag without a greater order");

  // The input side stalls only behind a full, untaken result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && in_v_r && last_r))
    else $error("input stalled without a blocked result");

  // A string that ends in the parse step yields a result word next cycle.
  a_end_gives_res: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_r) |=> out_valid)
    else $error("end of string produced no result");

endmodule

`default_nettype wire

>>> dv/version_string_parse_compare_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// version_string_parse_compare_checker: result predictor and scoreboard
// Watches the configuration port and both word channels. It rebuilds each
// parsed version from the accepted characters, queues the expected result
// word, and compares every accepted result word with the oldest one queued.
// ----------------------------------------------------------------------------

module version_string_parse_compare_checker #(
  parameter int COMP_WIDTH = vspc_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vspc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [vspc_pkg::NUM_WIDTH-1:0]      cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [7:0]                          in_ch,
  input  logic                                in_last,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_valid_res,
  input  logic [vspc_pkg::NUM_WIDTH-1:0]      out_major_num,
  input  logic [vspc_pkg::NUM_WIDTH-1:0]      out_minor_num,
  input  logic [vspc_pkg::NUM_WIDTH-1:0]      out_patch_num,
  input  logic signed [1:0]                   out_order,
  input  logic                                out_newer,
  output int                                  mismatches,
  output int                                  pending
);

  localparam logic [63:0] FIELD_MAX = (64'd1 << COMP_WIDTH) - 64'd1;

  typedef struct packed {
    logic                           ok;
    logic [vspc_pkg::NUM_WIDTH-1:0] major;
    logic [vspc_pkg::NUM_WIDTH-1:0] minor;
    logic [vspc_pkg::NUM_WIDTH-1:0] patch;
    logic signed [1:0]              ord;
    logic                           newer;
  } version_word_t;

  // Shadow of the installed version and of the parse state.
  logic [vspc_pkg::NUM_WIDTH-1:0] installed [3];
  logic [1:0]                     field_sel;
  logic [31:0]                    field_val [3];
  logic                           have_digit;
  logic                           lone_zero;
  logic                           broken;

  version_word_t expected_versions [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic void clear_parse();
    field_sel = vspc_pkg::FIELD_MAJOR;
    for (int k = 0; k < 3; k++) field_val[k] = '0;
    have_digit = 1'b0;
    lone_zero = 1'b0;
    broken = 1'b0;
  endfunction

  // One character of the string. Once the string is broken nothing else moves.
  function automatic void absorb_char(input logic [7:0] c);
    logic [63:0] grown;
    if (broken) return;
    if (c >= vspc_pkg::CHAR_ZERO && c <= vspc_pkg::CHAR_NINE) begin
      if (have_digit && lone_zero) begin
        broken = 1'b1;
        return;
      end
      grown = 64'(field_val[field_sel]) * 64'd10 + 64'(c - vspc_pkg::CHAR_ZERO);
      if (grown > FIELD_MAX) begin
        broken = 1'b1;
        return;
      end
      field_val[field_sel] = grown[31:0];
      if (!have_digit && c == vspc_pkg::CHAR_ZERO) lone_zero = 1'b1;
      have_digit = 1'b1;
    end else if (c == vspc_pkg::CHAR_DOT) begin
      if (!have_digit || field_sel == vspc_pkg::FIELD_PATCH) begin
        broken = 1'b1;
        return;
      end
      field_sel = field_sel + 2'd1;
      have_digit = 1'b0;
      lone_zero = 1'b0;
    end else begin
      broken = 1'b1;
    end
  endfunction

  // Result word for the string that just ended; parse state starts over.
  function automatic version_word_t close_string();
    version_word_t w;
    logic signed [1:0] ord;
    w = '0;
    ord = vspc_pkg::ORD_EQ;
    if (!broken && field_sel == vspc_pkg::FIELD_PATCH && have_digit) begin
      // Lexicographic: the first field that differs decides.
      for (int k = 0; k < 3; k++) begin
        if (ord == vspc_pkg::ORD_EQ && field_val[k] != 32'(installed[k]))
          ord = (field_val[k] > 32'(installed[k])) ? vspc_pkg::ORD_GT : vspc_pkg::ORD_LT;
      end
      w.ok = 1'b1;
      w.major = field_val[0][vspc_pkg::NUM_WIDTH-1:0];
      w.minor = field_val[1][vspc_pkg::NUM_WIDTH-1:0];
      w.patch = field_val[2][vspc_pkg::NUM_WIDTH-1:0];
      w.ord = ord;
      w.newer = (ord == vspc_pkg::ORD_GT);
    end
    clear_parse();
    return w;
  endfunction

  // Sample everything on the rising edge, before the edge takes effect.
  always @(posedge clk) begin
    version_word_t got;
    version_word_t want;
    version_word_t ended;
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) installed[k] = '0;
      clear_parse();
      expected_versions.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vspc_pkg::REG_CUR_MAJOR: installed[0] = cfg_wdata;
          vspc_pkg::REG_CUR_MINOR: installed[1] = cfg_wdata;
          vspc_pkg::REG_CUR_PATCH: installed[2] = cfg_wdata;
          default: ;
        endcase
      end

      // Result side first: a word leaving now is older than any string ending now.
      if (out_valid && out_ready) begin
        got = {out_valid_res, out_major_num, out_minor_num, out_patch_num,
               out_order, out_newer};
        if (expected_versions.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: ok=%0b %0d.%0d.%0d order=%0d newer=%0b",
                     got.ok, got.major, got.minor, got.patch, got.ord, got.newer);
          mismatches++;
        end else begin
          want = expected_versions.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("result mismatch: expected ok=%0b %0d.%0d.%0d order=%0d newer=%0b",
                       want.ok, want.major, want.minor, want.patch, want.ord, want.newer);
              $display("                 got      ok=%0b %0d.%0d.%0d order=%0d newer=%0b",
                       got.ok, got.major, got.minor, got.patch, got.ord, got.newer);
            end
            mismatches++;
          end
        end
      end

      if (in_valid && in_ready) begin
        absorb_char(in_ch);
        if (in_last) begin
          ended = close_string();
          expected_versions = {expected_versions, ended};
        end
      end
    end
    pending <= expected_versions.size();
  end

endmodule

>>> dv/version_string_parse_compare_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// version_string_parse_compare_tb: testbench for the version string parser
// Sends directed and random version strings one character per word, through
// phases of sender idling and receiver stalls, with the installed version
// rewritten between phases. The checker predicts and compares every result.
// ----------------------------------------------------------------------------

module version_string_parse_compare_tb;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_WORDS  = 300;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               cfg_we;
  logic [vspc_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
  logic [vspc_pkg::NUM_WIDTH-1:0]     cfg_wdata;
  logic                               in_valid;
  logic                               in_ready;
  logic [7:0]                         in_ch;
  logic                               in_last;
  logic                               out_valid;
  logic                               out_ready;
  logic                               out_valid_res;
  logic [vspc_pkg::NUM_WIDTH-1:0]     out_major_num;
  logic [vspc_pkg::NUM_WIDTH-1:0]     out_minor_num;
  logic [vspc_pkg::NUM_WIDTH-1:0]     out_patch_num;
  logic signed [1:0]                  out_order;
  logic                               out_newer;
  int                                 mismatches;
  int                                 pending;

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;
  int          words_sent = 0;
  int unsigned cur_ver [3];

  version_string_parse_compare dut (.*);

  version_string_parse_compare_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, or one long hold-off when asked.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: cycles in a row with no word moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("version_string_parse_compare_tb NOT OK");
    $finish;
  end

  // Offer one character and wait for it to be taken, then maybe go idle.
  task automatic put_word(input logic [7:0] c, input logic is_end);
    in_valid <= 1'b1;
    in_ch <= c;
    in_last <= is_end;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_chars(input logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) begin
      put_word(q[i], i == q.size() - 1);
      words_sent++;
    end
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q = {q, 8'(s[i])};
    send_chars(q);
  endtask

  // Field values cluster on the installed version so all three orders show up.
  function automatic int unsigned pick_field(input int unsigned cur);
    case ($urandom_range(7))
      0, 1, 2: return cur;
      3:       return cur + 1;
      4:       return (cur == 0) ? 0 : cur - 1;
      5:       return $urandom_range(65535);
      6:       return $urandom_range(99);
      default: begin
        case ($urandom_range(3))
          0:       return 0;
          1:       return 65535;
          2:       return 65536;
          default: return 9;
        endcase
      end
    endcase
  endfunction

  function automatic string zero_pad();
    string pad;
    pad = "";
    if ($urandom_range(19) == 0) pad = "0";
    return pad;
  endfunction

  // Mostly well-formed versions, some damaged ones, a little pure noise.
  task automatic send_random_string();
    logic [7:0]  q[$];
    string       s;
    int unsigned kind;
    int unsigned idx;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 8)) q = {q, 8'($urandom_range(255))};
    end else begin
      s = $sformatf("%s%0d.%s%0d.%s%0d",
                    zero_pad(), pick_field(cur_ver[0]),
                    zero_pad(), pick_field(cur_ver[1]),
                    zero_pad(), pick_field(cur_ver[2]));
      for (int i = 0; i < s.len(); i++) q = {q, 8'(s[i])};
      if (kind < 30) begin
        idx = $urandom_range(q.size() - 1);
        case ($urandom_range(3))
          0: q[idx] = 8'($urandom_range(255));
          1: q.delete(idx);
          2: q.insert(idx, vspc_pkg::CHAR_DOT);
          default: q.insert(idx, vspc_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        endcase
      end
    end
    send_chars(q);
  endtask

  // Stop offering, let every expected word arrive, then let the pipe empty.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_version(input int unsigned maj, input int unsigned mnr,
                               input int unsigned pat);
    cur_ver[0] = maj;
    cur_ver[1] = mnr;
    cur_ver[2] = pat;
    cfg_we <= 1'b1;
    cfg_index <= vspc_pkg::REG_CUR_MAJOR;
    cfg_wdata <= maj[vspc_pkg::NUM_WIDTH-1:0];
    @(posedge clk);
    cfg_index <= vspc_pkg::REG_CUR_MINOR;
    cfg_wdata <= mnr[vspc_pkg::NUM_WIDTH-1:0];
    @(posedge clk);
    cfg_index <= vspc_pkg::REG_CUR_PATCH;
    cfg_wdata <= pat[vspc_pkg::NUM_WIDTH-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] odd[$];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = vspc_pkg::REG_CUR_MAJOR;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_ch = '0;
    in_last = 1'b0;
    cur_ver = '{0, 0, 0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings against the reset version 0.0.0.
    send_text("0.0.0");
    send_text("65535.65535.65535");
    send_text("65536.0.0");
    send_text("01.2.3");
    send_text("7.0.00");
    send_text("1..2");
    send_text("1.2.");
    send_text("1.2");
    send_text("1.2.3.4");
    send_text(" 1.+2.-3");
    send_text(".");
    odd = {8'h39, 8'h2E, 8'h38, 8'h2E, 8'h37, 8'hFF};
    send_chars(odd);
    odd = {8'h00};
    send_chars(odd);

    // Random phases, each with its own idling pattern and installed version.
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
          write_version(65535, 65535, 65535);
        end
        1: begin
          tx_idle_pct = 78;
          rx_stall_pct = 0;
          write_version($urandom_range(9), $urandom_range(9), $urandom_range(9));
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 78;
          write_version($urandom_range(65535), $urandom_range(65535),
                        $urandom_range(65535));
        end
        default: begin
          tx_idle_pct = 17;
          rx_stall_pct = 17;
          write_version(0, 0, 0);
        end
      endcase
      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        // Back-pressure: hold the result side off while characters keep coming.
        if (ph == 0 && !hold_done && words_sent > 100) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        send_random_string();
      end
    end
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("version_string_parse_compare_tb OK");
    end else begin
      $display("version_string_parse_compare_tb NOT OK");
    end
    $finish;
  end

endmodule
